@@ rtl/scsm_pkg.sv @@
// ----------------------------------------------------------------------------
// scsm_pkg
// Shared types and constants for the signal color sequence monitor.
// ----------------------------------------------------------------------------
package scsm_pkg;

  localparam int LAMP_BITS  = 16;
  localparam int LAMP_IDX_W = 4;
  localparam int STAMP_W    = 32;

  // Color coding of a channel
  localparam logic [1:0] COLOR_DARK   = 2'd0;
  localparam logic [1:0] COLOR_RED    = 2'd1;
  localparam logic [1:0] COLOR_YELLOW = 2'd2;
  localparam logic [1:0] COLOR_GREEN  = 2'd3;

  typedef struct packed {
    logic [LAMP_BITS-1:0] red_lamps;
    logic [LAMP_BITS-1:0] yellow_lamps;
    logic [LAMP_BITS-1:0] green_lamps;
    logic [STAMP_W-1:0]   tick_time;
  } in_item_t;

  typedef struct packed {
    logic [LAMP_IDX_W-1:0] fault_channel;
    logic [1:0]            old_color;
    logic [1:0]            fresh_color;
    logic [STAMP_W-1:0]    fault_time;
    logic                  last_fault;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the tick, rewind the channel counter
    logic step;   // evaluate current channel and advance
    logic flush;  // push the held fault out as the last of the tick
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fault;       // current channel makes an illegal change
    logic pend_valid;  // a fault is held back waiting for its last flag
    logic last_ch;     // counter sits on the last lamp channel
    logic out_free;    // output register can take a transaction this cycle
  } ctrl_stat_t;

endpackage

@@ rtl/signal_color_sequence_monitor.sv @@
// ----------------------------------------------------------------------------
// signal_color_sequence_monitor
// Checks lamp color changes of up to sixteen signal channels per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per tick, carrying red/yellow/green lamp bitmaps
//           and a timestamp. Each channel's color is green over yellow over
//           red, else dark.
//   out_* : one transaction per illegal color change, in channel order, with
//           last_fault set on the final one of the tick. A tick with no
//           illegal change yields no transaction.
//   Sequence: a tick is captured, then the lamp channels are walked in order
//           (the channel walker compares a single channel per cycle unless
//           the walk is stalled), then the final held fault, if any, is
//           flushed. Channels 16 and up carry no lamps, are always dark and
//           are not walked.
//   A fault leaves the block one detected fault later (or at the flush),
//           since its last flag is only known then.
//   Reset: stored colors go dark and the first tick after reset only
//           records colors.
//   Stall: if out_ready is low the walk pauses on the next fault until the
//           output register drains; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module signal_color_sequence_monitor import scsm_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Only channels that own lamp bits need storage and scan cycles
  localparam int LAMP_CH = (CHANNELS < LAMP_BITS) ? CHANNELS : LAMP_BITS;
  localparam int CH_W    = (LAMP_CH > 1) ? $clog2(LAMP_CH) : 1;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  scsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scsm_dp #(
    .LAMP_CH (LAMP_CH),
    .CH_W    (CH_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Replacing a held fault must never overwrite an undrained output
  a_step_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && stat.fault && stat.pend_valid |-> stat.out_free)
    else $error("fault pushed while output register busy");

  // Flush only with a held fault and room for it
  a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> stat.pend_valid && stat.out_free)
    else $error("flush without held fault or output room");

  // No fault may be left held once the block is ready for the next tick
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.pend_valid)
    else $error("held fault lost across ticks");

  // After a flush the tick's final transaction is on the output
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> out_valid && out_data.last_fault)
    else $error("flushed transaction missing last flag");
`endif

endmodule

@@ rtl/scsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// scsm_ctrl
// Sequencer: takes a tick, walks the channels, flushes the final fault.
// ----------------------------------------------------------------------------
module scsm_ctrl import scsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   stall;

  assign in_ready = (state_r == ST_IDLE);

  // A second fault while one is held needs the output slot for the held one
  assign stall = stat.fault && stat.pend_valid && !stat.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.step = 1'b1;
          if (stat.last_ch) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/scsm_dp.sv @@
// ----------------------------------------------------------------------------
// scsm_dp
// Datapath: tick register, stored colors, channel counter, fault hold
// register and output register.
// ----------------------------------------------------------------------------
module scsm_dp import scsm_pkg::*; #(
  parameter int LAMP_CH = 16,
  parameter int CH_W    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  function automatic logic [1:0] lamp_color(input logic r, input logic y,
                                            input logic g);
    logic [1:0] c;
    if (g) begin
      c = COLOR_GREEN;
    end else if (y) begin
      c = COLOR_YELLOW;
    end else if (r) begin
      c = COLOR_RED;
    end else begin
      c = COLOR_DARK;
    end
    return c;
  endfunction

  function automatic logic change_allowed(input logic [1:0] prev,
                                          input logic [1:0] now);
    logic ok;
    if (prev == now || prev == COLOR_DARK || now == COLOR_DARK) begin
      ok = 1'b1;
    end else begin
      unique case (prev)
        COLOR_RED:    ok = (now == COLOR_GREEN);
        COLOR_GREEN:  ok = (now == COLOR_YELLOW);
        COLOR_YELLOW: ok = (now == COLOR_RED);
        default:      ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  in_item_t              tick_r;
  logic [CH_W-1:0]       ch_r;
  logic [1:0]            color_r [LAMP_CH];
  logic                  primed_r;
  logic                  pend_valid_r;
  out_item_t             pend_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [LAMP_IDX_W-1:0] lamp_idx;
  logic [1:0]            now_color;
  logic [1:0]            prev_color;
  logic                  fault_now;
  logic                  last_ch;
  logic                  out_free;
  logic                  push_held;
  out_item_t             fault_item;
  out_item_t             last_item;

  assign lamp_idx   = LAMP_IDX_W'(ch_r);
  assign now_color  = lamp_color(tick_r.red_lamps[lamp_idx],
                                 tick_r.yellow_lamps[lamp_idx],
                                 tick_r.green_lamps[lamp_idx]);
  assign prev_color = color_r[ch_r];
  assign fault_now  = primed_r && !change_allowed(prev_color, now_color);
  assign last_ch    = (ch_r == CH_W'(LAMP_CH - 1));
  assign out_free   = !out_valid_r || out_ready;

  // Held fault goes out (not last) when a newer fault replaces it
  assign push_held  = cmd.step && fault_now && pend_valid_r;

  always_comb begin
    fault_item.fault_channel = lamp_idx;
    fault_item.old_color     = prev_color;
    fault_item.fresh_color   = now_color;
    fault_item.fault_time    = tick_r.tick_time;
    fault_item.last_fault    = 1'b0;
  end

  // Held fault tagged as the final one of the tick
  always_comb begin
    last_item            = pend_r;
    last_item.last_fault = 1'b1;
  end

  assign stat.fault      = fault_now;
  assign stat.pend_valid = pend_valid_r;
  assign stat.last_ch    = last_ch;
  assign stat.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r         <= '0;
      primed_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < LAMP_CH; i++) begin
        color_r[i] <= COLOR_DARK;
      end
    end else begin
      if (cmd.load) begin
        ch_r <= '0;
      end else if (cmd.step) begin
        color_r[ch_r] <= now_color;
        ch_r          <= last_ch ? '0 : ch_r + CH_W'(1);
        if (last_ch) begin
          primed_r <= 1'b1;
        end
        if (fault_now) begin
          pend_valid_r <= 1'b1;
        end
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end

      if (push_held || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_r <= in_data;
    end
    if (cmd.step && fault_now) begin
      pend_r <= fault_item;
    end
    if (push_held) begin
      out_r <= pend_r;
    end else if (cmd.flush) begin
      out_r <= last_item;
    end
  end

endmodule
